// ----- rtl/wav_pcm16_stream_to_stereo_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the WAV PCM16 stream core
// Shared property forms, clocked on the rising edge and held off in reset.
// ---------------------------------------------------------------------------
`ifndef WAV_PCM16_STREAM_TO_STEREO_CORE_ASSERT_SVH
`define WAV_PCM16_STREAM_TO_STEREO_CORE_ASSERT_SVH

// Same-cycle implication
`define WPSC_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication
`define WPSC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- rtl/wpsc_pkg.sv -----
// ---------------------------------------------------------------------------
// wpsc_pkg
// Payload types, result codes and RIFF/WAVE constants for the stream core.
// ---------------------------------------------------------------------------
package wpsc_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_TAG    = 3'd1;
   localparam logic [2:0] ERR_FMT_SHORT  = 3'd2;
   localparam logic [2:0] ERR_BAD_FORMAT = 3'd3;
   localparam logic [2:0] ERR_NO_FMT     = 3'd4;
   localparam logic [2:0] ERR_BAD_RATE   = 3'd5;

   // Chunk tags, first byte in the top lane
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FORMAT_PCM   = 16'd1;
   localparam logic [15:0] PCM_BITS     = 16'd16;
   localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
   localparam logic [15:0] GAIN_DEFAULT = 16'd983;
   localparam logic [3:0]  RATE_NONE    = 4'd9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [2:0]         error_code;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [1:0]         channel_count;
      logic [31:0]        sample_rate;
      logic [3:0]         rate_index;
      logic [31:0]        data_bytes;
      logic               stream_done;
   } rsp_type;

   // Outcome of parsing one byte, before sample scaling
   typedef struct packed {
      logic               has_result;
      logic [1:0]         kind;
      logic [2:0]         code;
      logic signed [15:0] left_raw;
      logic signed [15:0] right_raw;
      logic [1:0]         channels;
      logic [31:0]        rate;
      logic [3:0]         rate_idx;
      logic [31:0]        bytes;
      logic               done;
   } step_type;

   // Map a sample rate to its table index, RATE_NONE when unsupported
   function automatic logic [3:0] rate_lookup(input logic [31:0] rate);
      logic [3:0] idx;
      case (rate)
         32'd8000:   idx = 4'd0;
         32'd11025:  idx = 4'd1;
         32'd16000:  idx = 4'd2;
         32'd22050:  idx = 4'd3;
         32'd32000:  idx = 4'd4;
         32'd44100:  idx = 4'd5;
         32'd48000:  idx = 4'd6;
         32'd96000:  idx = 4'd7;
         32'd192000: idx = 4'd8;
         default:    idx = RATE_NONE;
      endcase
      return idx;
   endfunction

endpackage

// ----- rtl/wpsc_scale.sv -----
// ---------------------------------------------------------------------------
// wpsc_scale
// Q15 gain on one sample: floor(sample * gain / 32768), saturated to 16 bits.
// ---------------------------------------------------------------------------
module wpsc_scale (
   input  logic signed [15:0] raw_sample,
   input  logic [15:0]        gain,
   output logic signed [15:0] scaled_sample
);

   logic signed [32:0] raw_ext;
   logic signed [32:0] gain_ext;
   logic signed [32:0] product;
   logic signed [17:0] shifted;

   // Multiply as signed with a zero-extended gain
   assign raw_ext  = {{17{raw_sample[15]}}, raw_sample};
   assign gain_ext = {17'd0, gain};
   assign product  = raw_ext * gain_ext;

   // Floor divide by 2^15
   assign shifted = product[32:15];

   // Clamp to the 16-bit range
   always_comb begin
      if (!shifted[17] && (shifted[16] || shifted[15])) begin
         scaled_sample = 16'sh7FFF;
      end else if (shifted[17] && !(shifted[16] && shifted[15])) begin
         scaled_sample = -16'sh8000;
      end else begin
         scaled_sample = shifted[15:0];
      end
   end

endmodule

// ----- rtl/wpsc_parse.sv -----
// ---------------------------------------------------------------------------
// wpsc_parse
// RIFF/WAVE chunk walker and PCM16 frame assembler, one byte per step.
// ---------------------------------------------------------------------------
module wpsc_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  wpsc_pkg::req_type item,
   output wpsc_pkg::step_type step
);

   localparam logic [2:0] PH_RIFF = 3'd0;
   localparam logic [2:0] PH_CHDR = 3'd1;
   localparam logic [2:0] PH_FMT  = 3'd2;
   localparam logic [2:0] PH_SKIP = 3'd3;
   localparam logic [2:0] PH_PAD  = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_IDLE = 3'd6;

   typedef struct packed {
      logic [2:0]  phase;
      logic [31:0] byte_count;
      logic [31:0] chunk_len;
      logic [31:0] tag_shift;
      logic        format_seen;
      logic [15:0] format_tag;
      logic [1:0]  channels;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [31:0] data_left;
      logic [15:0] assembly;
      logic [15:0] left_held;
      logic [1:0]  frame_idx;
   } parse_state_type;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type cur;

   logic [7:0]  b;
   logic [31:0] k;
   logic [31:0] tag_new;
   logic [31:0] len_new;
   logic [31:0] rate_new;
   logic [15:0] bits_new;
   logic [15:0] chan_word;
   logic [15:0] smp;
   logic [31:0] cnt_next;
   logic [31:0] left_new;
   logic [31:0] frame_bytes;
   logic [3:0]  idx;

   // OR a byte into one lane of a little-endian word
   function automatic logic [31:0] set_lane(input logic [31:0] word, input logic [1:0] lane,
                                            input logic [7:0] v);
      logic [31:0] res;
      res = word;
      case (lane)
         2'd0:    res[7:0]   = res[7:0] | v;
         2'd1:    res[15:8]  = res[15:8] | v;
         2'd2:    res[23:16] = res[23:16] | v;
         2'd3:    res[31:24] = res[31:24] | v;
         default: res = word;
      endcase
      return res;
   endfunction

   // Restart clears the parse state before the byte is taken
   assign cur = item.file_start ? '0 : state_ff;
   assign b   = item.data_byte;
   assign k   = cur.byte_count;

   assign tag_new     = {cur.tag_shift[23:0], b};
   assign cnt_next    = k + 32'd1;
   assign frame_bytes = {29'd0, cur.channels, 1'b0};
   assign left_new    = (cur.data_left != 32'd0) ? cur.data_left - 32'd1 : cur.data_left;
   assign smp         = cur.assembly | {b, 8'h00};
   assign idx         = wpsc_pkg::rate_lookup(cur.rate);

   // Advance the parse by one byte
   always_comb begin
      state_in  = cur;
      step      = '0;
      len_new   = '0;
      rate_new  = '0;
      bits_new  = '0;
      chan_word = '0;
      case (cur.phase)
         PH_RIFF: begin
            state_in.tag_shift  = tag_new;
            state_in.byte_count = cnt_next;
            if (k == 32'd3) begin
               state_in.chunk_len = (tag_new == wpsc_pkg::TAG_RIFF) ? 32'd1 : 32'd0;
            end
            if (k >= 32'd11) begin
               if (state_in.chunk_len != 32'd1 || tag_new != wpsc_pkg::TAG_WAVE) begin
                  state_in.phase = PH_IDLE;
                  step.has_result = 1'b1;
                  step.kind = wpsc_pkg::KIND_ERROR;
                  step.code = wpsc_pkg::ERR_BAD_TAG;
               end else begin
                  state_in.phase      = PH_CHDR;
                  state_in.byte_count = '0;
                  state_in.chunk_len  = '0;
               end
            end
         end
         PH_CHDR: begin
            if (k < 32'd4) begin
               state_in.tag_shift = tag_new;
               len_new = (k == 32'd0) ? 32'd0 : cur.chunk_len;
            end else begin
               len_new = set_lane(cur.chunk_len, k[1:0], b);
            end
            state_in.chunk_len  = len_new;
            state_in.byte_count = cnt_next;
            if (k >= 32'd7) begin
               state_in.byte_count = '0;
               if (state_in.tag_shift == wpsc_pkg::TAG_FMT) begin
                  if (len_new < wpsc_pkg::FMT_MIN_LEN) begin
                     state_in.phase = PH_IDLE;
                     step.has_result = 1'b1;
                     step.kind = wpsc_pkg::KIND_ERROR;
                     step.code = wpsc_pkg::ERR_FMT_SHORT;
                  end else begin
                     state_in.phase = PH_FMT;
                  end
               end else if (state_in.tag_shift == wpsc_pkg::TAG_DATA) begin
                  if (!cur.format_seen) begin
                     state_in.phase = PH_IDLE;
                     step.has_result = 1'b1;
                     step.kind = wpsc_pkg::KIND_ERROR;
                     step.code = wpsc_pkg::ERR_NO_FMT;
                  end else if (idx == wpsc_pkg::RATE_NONE) begin
                     state_in.phase = PH_IDLE;
                     step.has_result = 1'b1;
                     step.kind = wpsc_pkg::KIND_ERROR;
                     step.code = wpsc_pkg::ERR_BAD_RATE;
                  end else begin
                     state_in.data_left = len_new;
                     state_in.frame_idx = '0;
                     state_in.phase = (len_new < frame_bytes) ? PH_IDLE : PH_DATA;
                     step.has_result = 1'b1;
                     step.kind     = wpsc_pkg::KIND_HEADER;
                     step.channels = cur.channels;
                     step.rate     = cur.rate;
                     step.rate_idx = idx;
                     step.bytes    = len_new;
                     step.done     = (len_new < frame_bytes);
                  end
               end else begin
                  state_in.phase = (len_new == 32'd0) ? PH_CHDR : PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            if (k == 32'd0) begin
               state_in.format_tag = {8'd0, b};
            end else if (k == 32'd1) begin
               state_in.format_tag = cur.format_tag | {b, 8'd0};
            end else if (k == 32'd2) begin
               state_in.assembly = {8'd0, b};
            end else if (k == 32'd3) begin
               chan_word = cur.assembly | {b, 8'd0};
               state_in.channels = (chan_word == 16'd1 || chan_word == 16'd2) ?
                                   chan_word[1:0] : 2'd0;
               state_in.assembly = '0;
            end else if (k >= 32'd4 && k <= 32'd7) begin
               rate_new = (k == 32'd4) ? 32'd0 : cur.rate;
               state_in.rate = set_lane(rate_new, k[1:0], b);
            end else if (k == 32'd14) begin
               state_in.bits = {8'd0, b};
            end else if (k == 32'd15) begin
               state_in.bits = cur.bits | {b, 8'd0};
            end
            bits_new = state_in.bits;
            state_in.byte_count = cnt_next;
            if (k >= 32'd15) begin
               if (cur.format_tag != wpsc_pkg::FORMAT_PCM || cur.channels == 2'd0 ||
                   bits_new != wpsc_pkg::PCM_BITS) begin
                  state_in.phase = PH_IDLE;
                  step.has_result = 1'b1;
                  step.kind = wpsc_pkg::KIND_ERROR;
                  step.code = wpsc_pkg::ERR_BAD_FORMAT;
               end else begin
                  state_in.format_seen = 1'b1;
                  state_in.chunk_len   = cur.chunk_len - wpsc_pkg::FMT_MIN_LEN;
                  state_in.byte_count  = '0;
                  state_in.phase = (state_in.chunk_len == 32'd0) ? PH_CHDR : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            state_in.byte_count = cnt_next;
            if (cnt_next >= cur.chunk_len) begin
               state_in.byte_count = '0;
               state_in.phase = cur.chunk_len[0] ? PH_PAD : PH_CHDR;
            end
         end
         PH_PAD: begin
            state_in.byte_count = '0;
            state_in.phase      = PH_CHDR;
         end
         PH_DATA: begin
            state_in.data_left = left_new;
            if (cur.frame_idx == 2'd0 || cur.frame_idx == 2'd2) begin
               state_in.assembly  = {8'd0, b};
               state_in.frame_idx = cur.frame_idx + 2'd1;
            end else if (cur.frame_idx == 2'd1 && cur.channels == 2'd2) begin
               state_in.left_held = smp;
               state_in.frame_idx = 2'd2;
            end else begin
               state_in.frame_idx = '0;
               if (left_new < frame_bytes) begin
                  state_in.phase = PH_IDLE;
               end
               step.has_result = 1'b1;
               step.kind       = wpsc_pkg::KIND_FRAME;
               step.left_raw   = (cur.frame_idx == 2'd1) ? smp : cur.left_held;
               step.right_raw  = smp;
               step.done       = (left_new < frame_bytes);
            end
         end
         default: begin
            state_in = cur;
         end
      endcase
   end

   // Hold state unless a byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/wav_pcm16_stream_to_stereo_core.sv -----
// ---------------------------------------------------------------------------
// wav_pcm16_stream_to_stereo_core
// WAV byte stream parser with stereo PCM16 output and Q15 volume.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while rsp_stall does not hold a full
//   result register; the parse step, rate lookup and one 16x16 multiply
//   per channel sit between the input and result registers.
// Reset: parse state returns to the RIFF header, both stages empty,
//   volume gain returns to 983.
module wav_pcm16_stream_to_stereo_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wpsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wpsc_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [15:0]       csr_write_data
);

   logic                gain_ff;
   logic [15:0]         volume_gain_ff;
   logic                in_valid_ff;
   wpsc_pkg::req_type   in_ff;
   logic                out_valid_ff;
   wpsc_pkg::rsp_type   out_ff;
   logic                advance;
   wpsc_pkg::step_type  step;
   logic signed [15:0]  left_scaled;
   logic signed [15:0]  right_scaled;

   // Volume register
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_gain_ff <= wpsc_pkg::GAIN_DEFAULT;
         gain_ff        <= 1'b0;
      end else if (csr_write_en) begin
         volume_gain_ff <= csr_write_data;
         gain_ff        <= 1'b1;
      end
   end

   // Consume the held byte when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_ff <= req_data;
      end
   end

   wpsc_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_ff),
      .step    (step)
   );

   wpsc_scale u_scale_left (
      .raw_sample    (step.left_raw),
      .gain          (volume_gain_ff),
      .scaled_sample (left_scaled)
   );

   wpsc_scale u_scale_right (
      .raw_sample    (step.right_raw),
      .gain          (volume_gain_ff),
      .scaled_sample (right_scaled)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step.has_result;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.has_result) begin
         out_ff.result_kind   <= step.kind;
         out_ff.error_code    <= step.code;
         out_ff.left_sample   <= left_scaled;
         out_ff.right_sample  <= right_scaled;
         out_ff.channel_count <= step.channels;
         out_ff.sample_rate   <= step.rate;
         out_ff.rate_index    <= step.rate_idx;
         out_ff.data_bytes    <= step.bytes;
         out_ff.stream_done   <= step.done;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Checks
`include "wav_pcm16_stream_to_stereo_core_assert.svh"

   `WPSC_ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall, in_valid_ff, "stall with empty input register")
   `WPSC_ASSERT_NEXT(a_result_lands, clock, reset, advance && step.has_result, rsp_valid, "parsed result not presented")
   `WPSC_ASSERT_IMPLY(a_frame_clean, clock, reset, rsp_valid && rsp_data.result_kind == wpsc_pkg::KIND_FRAME, rsp_data.error_code == wpsc_pkg::ERR_NONE && rsp_data.data_bytes == 32'd0, "frame carries header fields")
   `WPSC_ASSERT_IMPLY(a_header_rate, clock, reset, rsp_valid && rsp_data.result_kind == wpsc_pkg::KIND_HEADER, rsp_data.rate_index < wpsc_pkg::RATE_NONE && (rsp_data.channel_count == 2'd1 || rsp_data.channel_count == 2'd2), "header with bad rate or channels")
   `WPSC_ASSERT_NEXT(a_gain_written, clock, reset, csr_write_en, gain_ff && volume_gain_ff == $past(csr_write_data), "volume write lost")

endmodule

// ----- dv/tb_wav_pcm16_stream_to_stereo_core.sv -----
// ---------------------------------------------------------------------------
// tb_wav_pcm16_stream_to_stereo_core
// Drives WAV byte streams through the core and checks every result against a
// byte-level parse model kept in the bench. Directed files cover each error
// path, odd chunk padding, repeated fmt, empty and truncated data, and sample
// extremes. Random files follow, mostly well formed, under several volume
// gains, with random request gaps and result stalls.
// ---------------------------------------------------------------------------
module tb_wav_pcm16_stream_to_stereo_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int STUCK_LIMIT  = 2000;
   localparam int PHASE_BYTES  = 150;
   localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

   typedef enum logic [2:0] {
      PHASE_RIFF, PHASE_CHDR, PHASE_FMT, PHASE_SKIP, PHASE_PAD, PHASE_DATA, PHASE_IDLE
   } parse_phase_type;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   wpsc_pkg::req_type req_data       = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   wpsc_pkg::rsp_type rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [15:0]       csr_write_data = '0;

   // Parse model state
   parse_phase_type ps_phase;
   logic [31:0]  ps_count;
   logic [31:0]  ps_len;
   logic [31:0]  ps_tag;
   logic         ps_fmt_ok;
   logic [15:0]  ps_format;
   logic [1:0]   ps_chans;
   logic [31:0]  ps_rate;
   logic [15:0]  ps_bits;
   logic [31:0]  ps_left_bytes;
   logic [15:0]  ps_low;
   logic [15:0]  ps_left;
   logic [1:0]   ps_slot;
   logic [15:0]  gain_q15 = wpsc_pkg::GAIN_DEFAULT;

   wpsc_pkg::req_type pending_req_q[$];
   wpsc_pkg::rsp_type expected_rsp_q[$];
   int unsigned queued_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned stuck_cycles   = 0;
   int unsigned send_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned gap_pct        = 20;
   int unsigned stall_pct      = 20;
   bit          quiet_run      = 1'b0;
   bit          start_pending  = 1'b0;

   wav_pcm16_stream_to_stereo_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Parse model
   // -------------------------------------------------------------------------
   function automatic logic [31:0] rate_hz(input int idx);
      case (idx)
         0:       return 32'd8000;
         1:       return 32'd11025;
         2:       return 32'd16000;
         3:       return 32'd22050;
         4:       return 32'd32000;
         5:       return 32'd44100;
         6:       return 32'd48000;
         7:       return 32'd96000;
         8:       return 32'd192000;
         default: return 32'd0;
      endcase
   endfunction

   function automatic void clear_parse();
      ps_phase      = PHASE_RIFF;
      ps_count      = '0;
      ps_len        = '0;
      ps_tag        = '0;
      ps_fmt_ok     = 1'b0;
      ps_format     = '0;
      ps_chans      = '0;
      ps_rate       = '0;
      ps_bits       = '0;
      ps_left_bytes = '0;
      ps_low        = '0;
      ps_left       = '0;
      ps_slot       = '0;
   endfunction

   // Q15 scale with floor, saturated to 16 bits
   function automatic logic signed [15:0] apply_gain(input logic [15:0] raw);
      longint prod;
      longint q;
      prod = longint'($signed(raw)) * longint'(gain_q15);
      q = prod >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic wpsc_pkg::rsp_type error_result(input logic [2:0] code);
      wpsc_pkg::rsp_type r;
      r = '0;
      r.result_kind = wpsc_pkg::KIND_ERROR;
      r.error_code = code;
      ps_phase = PHASE_IDLE;
      return r;
   endfunction

   function automatic void enter_skip(input logic [31:0] len);
      ps_len = len;
      ps_count = '0;
      ps_phase = (len == 0) ? PHASE_CHDR : PHASE_SKIP;
   endfunction

   // Advance the parse by one byte and queue the result it causes, if any
   function automatic void parse_byte(input wpsc_pkg::req_type req);
      logic [7:0]  b;
      logic [31:0] k;
      logic [2:0]  frame_len;
      logic [1:0]  slot;
      logic [15:0] word;
      logic [3:0]  idx;
      wpsc_pkg::rsp_type r;
      bit          emit;
      b = req.data_byte;
      r = '0;
      emit = 1'b0;
      if (req.file_start) clear_parse();
      k = ps_count;
      case (ps_phase)
         PHASE_RIFF: begin
            ps_tag = {ps_tag[23:0], b};
            ps_count = k + 1;
            if (k == 3) ps_len = (ps_tag == wpsc_pkg::TAG_RIFF) ? 32'd1 : 32'd0;
            if (k >= 11) begin
               if (ps_len != 32'd1 || ps_tag != wpsc_pkg::TAG_WAVE) begin
                  r = error_result(wpsc_pkg::ERR_BAD_TAG);
                  emit = 1'b1;
               end else begin
                  ps_phase = PHASE_CHDR;
                  ps_count = '0;
                  ps_len = '0;
               end
            end
         end
         PHASE_CHDR: begin
            if (k < 4) begin
               ps_tag = {ps_tag[23:0], b};
               if (k == 0) ps_len = '0;
            end else begin
               ps_len = ps_len | ({24'd0, b} << (8 * k[1:0]));
            end
            ps_count = k + 1;
            if (k >= 7) begin
               ps_count = '0;
               if (ps_tag == wpsc_pkg::TAG_FMT) begin
                  if (ps_len < wpsc_pkg::FMT_MIN_LEN) begin
                     r = error_result(wpsc_pkg::ERR_FMT_SHORT);
                     emit = 1'b1;
                  end else begin
                     ps_phase = PHASE_FMT;
                  end
               end else if (ps_tag == wpsc_pkg::TAG_DATA) begin
                  idx = wpsc_pkg::RATE_NONE;
                  for (int i = 0; i < 9; i++) begin
                     if (rate_hz(i) == ps_rate) idx = i[3:0];
                  end
                  if (!ps_fmt_ok) begin
                     r = error_result(wpsc_pkg::ERR_NO_FMT);
                  end else if (idx == wpsc_pkg::RATE_NONE) begin
                     r = error_result(wpsc_pkg::ERR_BAD_RATE);
                  end else begin
                     frame_len = {ps_chans, 1'b0};
                     ps_left_bytes = ps_len;
                     ps_slot = '0;
                     r.result_kind = wpsc_pkg::KIND_HEADER;
                     r.channel_count = ps_chans;
                     r.sample_rate = ps_rate;
                     r.rate_index = idx;
                     r.data_bytes = ps_len;
                     r.stream_done = (ps_left_bytes < {29'd0, frame_len});
                     ps_phase = r.stream_done ? PHASE_IDLE : PHASE_DATA;
                  end
                  emit = 1'b1;
               end else begin
                  enter_skip(ps_len);
               end
            end
         end
         PHASE_FMT: begin
            case (k)
               0: ps_format = {8'd0, b};
               1: ps_format = ps_format | {b, 8'd0};
               2: ps_low = {8'd0, b};
               3: begin
                  word = ps_low | {b, 8'd0};
                  ps_chans = (word == 16'd1 || word == 16'd2) ? word[1:0] : 2'd0;
                  ps_low = '0;
               end
               4: ps_rate = {24'd0, b};
               5, 6, 7: ps_rate = ps_rate | ({24'd0, b} << (8 * k[1:0]));
               14: ps_bits = {8'd0, b};
               15: ps_bits = ps_bits | {b, 8'd0};
               default: ;
            endcase
            ps_count = k + 1;
            if (k >= 15) begin
               if (ps_format != wpsc_pkg::FORMAT_PCM || ps_chans == 0 ||
                   ps_bits != wpsc_pkg::PCM_BITS) begin
                  r = error_result(wpsc_pkg::ERR_BAD_FORMAT);
                  emit = 1'b1;
               end else begin
                  ps_fmt_ok = 1'b1;
                  enter_skip(ps_len - wpsc_pkg::FMT_MIN_LEN);
               end
            end
         end
         PHASE_SKIP: begin
            ps_count = k + 1;
            if (ps_count >= ps_len) begin
               ps_count = '0;
               ps_phase = ps_len[0] ? PHASE_PAD : PHASE_CHDR;
            end
         end
         PHASE_PAD: begin
            ps_count = '0;
            ps_phase = PHASE_CHDR;
         end
         PHASE_DATA: begin
            frame_len = {ps_chans, 1'b0};
            slot = ps_slot;
            if (ps_left_bytes > 0) ps_left_bytes = ps_left_bytes - 1;
            if (slot == 0 || slot == 2) begin
               ps_low = {8'd0, b};
               ps_slot = slot + 2'd1;
            end else begin
               word = {b, ps_low[7:0]};
               if (slot == 1 && ps_chans == 2'd2) begin
                  ps_left = word;
                  ps_slot = 2'd2;
               end else begin
                  ps_slot = '0;
                  r.result_kind = wpsc_pkg::KIND_FRAME;
                  r.stream_done = (ps_left_bytes < {29'd0, frame_len});
                  if (r.stream_done) ps_phase = PHASE_IDLE;
                  r.left_sample = apply_gain((slot == 1) ? word : ps_left);
                  r.right_sample = apply_gain(word);
                  emit = 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (emit) expected_rsp_q.push_back(r);
   endfunction

   // -------------------------------------------------------------------------
   // Stream builders
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      wpsc_pkg::req_type item;
      item.data_byte = b;
      item.file_start = start_pending;
      start_pending = 1'b0;
      pending_req_q.push_back(item);
      queued_count++;
   endtask

   task automatic send_tag(input logic [31:0] tag);
      for (int i = 3; i >= 0; i--) send_byte(tag[8*i +: 8]);
   endtask

   task automatic send_le32(input logic [31:0] value);
      for (int i = 0; i < 4; i++) send_byte(value[8*i +: 8]);
   endtask

   task automatic send_le16(input logic [15:0] value);
      send_byte(value[7:0]);
      send_byte(value[15:8]);
   endtask

   task automatic send_riff_head(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
      start_pending = 1'b1;
      send_tag(riff_tag);
      send_le32($urandom);
      send_tag(wave_tag);
   endtask

   // Chunk with a random body and its pad byte when the length is odd
   task automatic send_chunk(input logic [31:0] tag, input int len);
      send_tag(tag);
      send_le32(len);
      repeat (len) send_byte(8'($urandom));
      if (len % 2 == 1) send_byte(8'($urandom));
   endtask

   task automatic send_fmt(input logic [15:0] code, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [15:0] bits, input int extra);
      send_tag(wpsc_pkg::TAG_FMT);
      send_le32(32'(16 + extra));
      send_le16(code);
      send_le16(chans);
      send_le32(rate);
      send_le32($urandom);
      send_le16(16'($urandom));
      send_le16(bits);
      repeat (extra) send_byte(8'($urandom));
      if (extra % 2 == 1) send_byte(8'($urandom));
   endtask

   // Favor the sample extremes in the byte mix
   function automatic logic [7:0] sample_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_data(input logic [31:0] len, input int count);
      send_tag(wpsc_pkg::TAG_DATA);
      send_le32(len);
      repeat (count) send_byte(sample_byte());
   endtask

   task automatic send_random_file();
      int          pick;
      int          dlen;
      int          extra;
      logic [15:0] code;
      logic [15:0] word;
      logic [15:0] bits;
      logic [31:0] rate;
      pick = $urandom_range(99);
      word = 16'($urandom_range(2, 1));
      rate = rate_hz($urandom_range(8));
      extra = ($urandom_range(3) == 0) ? $urandom_range(5) : 0;
      dlen = ($urandom_range(4) == 0) ? $urandom_range(64) : $urandom_range(16);
      if (pick < 6) begin
         // one flipped bit in either tag
         if ($urandom_range(1))
            send_riff_head(wpsc_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(31)),
                           wpsc_pkg::TAG_WAVE);
         else
            send_riff_head(wpsc_pkg::TAG_RIFF,
                           wpsc_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(31)));
      end else if (pick < 10) begin
         send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
         send_tag(wpsc_pkg::TAG_FMT);
         send_le32($urandom_range(15));
      end else if (pick < 16) begin
         code = wpsc_pkg::FORMAT_PCM;
         bits = wpsc_pkg::PCM_BITS;
         case ($urandom_range(2))
            0: code = 16'($urandom);
            1: word = $urandom_range(1) ? 16'($urandom) : 16'(3 * $urandom_range(1));
            default: bits = $urandom_range(1) ? 16'($urandom) : 16'd8;
         endcase
         send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
         send_fmt(code, word, rate, bits, extra);
         send_data(dlen, dlen);
      end else if (pick < 19) begin
         send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
         if ($urandom_range(1)) send_chunk(TAG_LIST, $urandom_range(5));
         send_data(dlen, dlen);
      end else if (pick < 24) begin
         send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
         send_fmt(wpsc_pkg::FORMAT_PCM, word, $urandom, wpsc_pkg::PCM_BITS, extra);
         send_data(dlen, dlen);
      end else if (pick < 28) begin
         // cut inside the first chunk header; the next file restarts the parse
         send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
         repeat ($urandom_range(7)) send_byte(8'($urandom));
      end else begin
         send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
         if ($urandom_range(2) == 0) send_chunk($urandom, $urandom_range(7));
         if ($urandom_range(9) == 0)
            send_fmt(wpsc_pkg::FORMAT_PCM, 16'($urandom_range(2, 1)),
                     rate_hz($urandom_range(8)), wpsc_pkg::PCM_BITS, 0);
         send_fmt(wpsc_pkg::FORMAT_PCM, word, rate, wpsc_pkg::PCM_BITS, extra);
         if ($urandom_range(3) == 0) send_chunk(TAG_LIST, $urandom_range(5));
         if ($urandom_range(15) == 0)
            send_data(32'hFFFF_FFFF - $urandom_range(3), $urandom_range(24, 8));
         else if ($urandom_range(4) == 0)
            send_data(dlen, $urandom_range(dlen));
         else
            send_data(dlen, dlen + $urandom_range(3));
      end
      // stray bytes with file_start low
      if ($urandom_range(9) == 0) repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
   endtask

   task automatic send_directed_files();
      // stereo 44.1 kHz, odd LIST chunk with pad, sample extremes, one trailing byte
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_chunk(TAG_LIST, 3);
      send_fmt(wpsc_pkg::FORMAT_PCM, 16'd2, 32'd44100, wpsc_pkg::PCM_BITS, 0);
      send_tag(wpsc_pkg::TAG_DATA);
      send_le32(32'd9);
      send_le16(16'h7FFF);
      send_le16(16'h8000);
      send_le16(16'h0000);
      send_le16(16'hFFFF);
      send_byte(8'h5A);
      // bytes after the last frame
      send_byte(8'hFF);
      send_byte(8'h00);
      // bad RIFF tag, then bad WAVE tag
      send_riff_head(32'h5249_4658, wpsc_pkg::TAG_WAVE);
      send_riff_head(wpsc_pkg::TAG_RIFF, 32'h5741_5646);
      // fmt chunk too short
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_tag(wpsc_pkg::TAG_FMT);
      send_le32(32'd15);
      // non-PCM format
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_fmt(16'd3, 16'd1, 32'd8000, wpsc_pkg::PCM_BITS, 0);
      // data chunk ahead of fmt, after an empty chunk
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_chunk(32'h6A75_6E6B, 0);
      send_data(32'd4, 4);
      // unsupported rate
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_fmt(wpsc_pkg::FORMAT_PCM, 16'd1, 32'hFFFF_FFFF, wpsc_pkg::PCM_BITS, 2);
      send_data(32'd2, 2);
      // repeated fmt with odd tail, then data too short for a stereo frame
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_fmt(wpsc_pkg::FORMAT_PCM, 16'd1, 32'd8000, wpsc_pkg::PCM_BITS, 1);
      send_fmt(wpsc_pkg::FORMAT_PCM, 16'd2, 32'd192000, wpsc_pkg::PCM_BITS, 0);
      send_data(32'd3, 3);
      // largest data length, cut short by a restart inside the RIFF header
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_fmt(wpsc_pkg::FORMAT_PCM, 16'd1, 32'd11025, wpsc_pkg::PCM_BITS, 0);
      send_data(32'hFFFF_FFFF, 6);
      start_pending = 1'b1;
      send_tag(wpsc_pkg::TAG_RIFF);
      send_byte(8'h00);
      // plain mono file
      send_riff_head(wpsc_pkg::TAG_RIFF, wpsc_pkg::TAG_WAVE);
      send_fmt(wpsc_pkg::FORMAT_PCM, 16'd1, 32'd22050, wpsc_pkg::PCM_BITS, 0);
      send_data(32'd4, 4);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: present queued bytes, hold while stalled, insert gaps
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      wpsc_pkg::req_type next_item;
      logic    next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_data);
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            next_item = req_data;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_req_q.size() > 0) begin
               if (!quiet_run && $urandom_range(99) < gap_pct) begin
                  send_gap = $urandom_range(18);
               end else begin
                  next_valid = 1'b1;
                  next_item = pending_req_q.pop_front();
               end
            end
            req_valid <= next_valid;
            req_data <= next_item;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor: compare against the oldest expectation, stall in bursts
   // -------------------------------------------------------------------------
   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      wpsc_pkg::rsp_type want;
      logic    next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result with no request behind it, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("result_kind", 32'(want.result_kind), 32'(rsp_data.result_kind));
               check_field("error_code", 32'(want.error_code), 32'(rsp_data.error_code));
               check_field("left_sample", 32'(want.left_sample), 32'(rsp_data.left_sample));
               check_field("right_sample", 32'(want.right_sample),
                           32'(rsp_data.right_sample));
               check_field("channel_count", 32'(want.channel_count),
                           32'(rsp_data.channel_count));
               check_field("sample_rate", want.sample_rate, rsp_data.sample_rate);
               check_field("rate_index", 32'(want.rate_index), 32'(rsp_data.rate_index));
               check_field("data_bytes", want.data_bytes, rsp_data.data_bytes);
               check_field("stream_done", 32'(want.stream_done), 32'(rsp_data.stream_done));
            end
         end
         next_stall = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (!quiet_run && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(18);
            next_stall = 1'b1;
         end
         rsp_stall <= next_stall;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles with no handshake on either channel
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles = 0;
      else
         stuck_cycles++;
   end

   initial begin : watchdog
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sequence: reset, directed files, then random files under several gains
   // -------------------------------------------------------------------------
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_req_q.size() != 0 || req_valid || send_gap != 0 ||
             expected_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(input logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      gain_q15 = value;
   endtask

   initial begin : run_sequence
      logic [15:0] phase_gain[7];
      int unsigned phase_end;
      clear_parse();
      phase_gain = '{16'd32768, 16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(65534, 2)),
                     16'($urandom_range(32768)), 16'd32768};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_directed_files();

      for (int p = 0; p < 7; p++) begin
         wait_idle();
         write_gain(phase_gain[p]);
         // vary the pressure; every third phase runs without gaps
         gap_pct = (p % 3 == 2) ? 0 : 10 + 10 * (p % 3);
         stall_pct = (p % 3 == 2) ? 0 : 30 - 10 * (p % 3);
         // drop all idling for the closing phase
         if (p == 6) quiet_run = 1'b1;
         phase_end = queued_count + PHASE_BYTES;
         while (queued_count < phase_end) send_random_file();
      end

      wait_idle();
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
